### src/qse_pkg.sv
// shared constants and types for the quicksort engine
`timescale 1ns / 1ps
package qse_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // one pending range on the sort stack
  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } range_t;

  localparam int RANGE_W = $bits(range_t);

endpackage

### src/qse_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module qse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/quicksort_engine_unit.sv
// quicksort engine top level: load, in-place hoare quicksort, ordered readout
`timescale 1ns / 1ps
// Values are loaded one per transfer into a 64-entry element ram; a transfer
// with last set, or the 64th transfer, closes the set. The block then stalls
// its input while a small sequencer sorts the set in place with quicksort
// (first element as pivot, hoare partition, range stack in a second ram),
// using one signed comparator against the held pivot. Both scans test one
// element per cycle through the registered ram port. Each pass pops a range,
// loads its pivot, scans and swaps out-of-place pairs, then places the pivot
// and pushes the halves. Results then stream out in ascending order, each one
// held while the output is stalled, with final_res on the greatest element;
// the input reopens once that last transfer completes. No clearing pass is
// needed.
module quicksort_engine_unit
  import qse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [DATA_WIDTH-1:0] out_sorted_value,
  output logic                  out_final_res
);

  typedef enum logic [3:0] {
    S_LOAD, S_POP, S_POP_WAIT, S_PIV, S_UP_STEP, S_UP_CHK, S_DN_STEP, S_DN_CHK,
    S_SWAP2, S_FIN1, S_FIN2, S_PUSH_R, S_OUT_RD, S_OUT_WAIT, S_OUT_HOLD
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;        // elements loaded, then set size
  cnt_t   sp_r, sp_nxt;          // stack fill
  idx_t   lo_r, lo_nxt;
  idx_t   hi_r, hi_nxt;
  cnt_t   up_r, up_nxt;
  cnt_t   dn_r, dn_nxt;
  cnt_t   k_r, k_nxt;
  data_t  pv_r, pv_nxt;
  data_t  a_r, a_nxt;
  data_t  b_r, b_nxt;
  logic   out_valid_r, out_valid_nxt;
  data_t  out_val_r, out_val_nxt;
  logic   out_fin_r, out_fin_nxt;

  // element ram ports
  logic   el_we;
  idx_t   el_waddr, el_raddr;
  data_t  el_wdata, el_rdata;
  logic [DATA_WIDTH-1:0] el_rdata_raw;

  // stack ram ports
  logic   st_we;
  idx_t   st_waddr, st_raddr;
  range_t st_wdata, st_rdata;
  logic [RANGE_W-1:0] st_rdata_raw;

  logic   in_xfer, out_xfer;
  logic   closes;
  cnt_t   up_inc, dn_dec, hi_ext, lo_ext;
  logic   le_pv, gt_pv;

  assign in_stall         = (state_r != S_LOAD);
  assign in_xfer          = in_valid && !in_stall;
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_val_r;
  assign out_final_res    = out_fin_r;
  assign out_xfer         = out_valid_r && !out_stall;

  assign el_rdata = data_t'(el_rdata_raw);
  assign st_rdata = range_t'(st_rdata_raw);

  qse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_elem (
    .clk     (clk),
    .wr_en   (el_we),
    .wr_addr (el_waddr),
    .wr_data (el_wdata),
    .rd_addr (el_raddr),
    .rd_data (el_rdata_raw)
  );

  qse_ram #(.WIDTH(RANGE_W), .DEPTH(DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (st_raddr),
    .rd_data (st_rdata_raw)
  );

  // shared comparator against the pivot
  assign le_pv  = (el_rdata <= pv_r);
  assign gt_pv  = (el_rdata > pv_r);
  assign up_inc = up_r + cnt_t'(1);
  assign dn_dec = dn_r - cnt_t'(1);
  assign hi_ext = {1'b0, hi_r};
  assign lo_ext = {1'b0, lo_r};
  assign closes = in_last || (cnt_r == cnt_t'(DEPTH - 1));

  // sequencer next state and ram control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    up_nxt        = up_r;
    dn_nxt        = dn_r;
    k_nxt         = k_r;
    pv_nxt        = pv_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_fin_nxt   = out_fin_r;
    el_we         = 1'b0;
    el_waddr      = up_r[IDX_W-1:0];
    el_wdata      = b_r;
    el_raddr      = up_inc[IDX_W-1:0];
    st_we         = 1'b0;
    st_waddr      = sp_r[IDX_W-1:0];
    st_wdata      = '{lo: lo_r, hi: hi_r};
    st_raddr      = dn_r[IDX_W-1:0];
    case (state_r)
      S_LOAD: begin
        el_waddr = cnt_r[IDX_W-1:0];
        el_wdata = in_value;
        if (in_xfer) begin
          el_we   = 1'b1;
          cnt_nxt = cnt_r + cnt_t'(1);
          if (closes) begin
            if (cnt_r == '0) begin
              k_nxt     = '0;
              state_nxt = S_OUT_RD;
            end else begin
              st_we     = 1'b1;
              st_waddr  = '0;
              st_wdata  = '{lo: '0, hi: cnt_r[IDX_W-1:0]};
              sp_nxt    = cnt_t'(1);
              state_nxt = S_POP;
            end
          end
        end
      end
      S_POP: begin
        st_raddr = sp_r[IDX_W-1:0] - idx_t'(1);
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          sp_nxt    = sp_r - cnt_t'(1);
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        lo_nxt   = st_rdata.lo;
        hi_nxt   = st_rdata.hi;
        el_raddr = st_rdata.lo;
        if (st_rdata.lo >= st_rdata.hi) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        pv_nxt    = el_rdata;
        up_nxt    = lo_ext;
        dn_nxt    = hi_ext + cnt_t'(1);
        state_nxt = S_UP_STEP;
      end
      // left scan: bound test before the element read
      S_UP_STEP: begin
        up_nxt = up_inc;
        if (up_inc + cnt_t'(1) <= hi_ext + cnt_t'(1) && up_inc <= hi_ext) begin
          el_raddr  = up_inc[IDX_W-1:0];
          state_nxt = S_UP_CHK;
        end else begin
          state_nxt = S_DN_STEP;
        end
      end
      S_UP_CHK: begin
        if (le_pv) begin
          el_raddr  = up_inc[IDX_W-1:0];
          up_nxt    = up_inc;
          if (up_inc <= hi_ext) begin
            state_nxt = S_UP_CHK;
          end else begin
            state_nxt = S_DN_STEP;
          end
        end else begin
          a_nxt     = el_rdata;
          state_nxt = S_DN_STEP;
        end
      end
      // right scan, stops at the pivot at the latest
      S_DN_STEP: begin
        dn_nxt    = dn_dec;
        el_raddr  = dn_dec[IDX_W-1:0];
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (gt_pv) begin
          dn_nxt    = dn_dec;
          el_raddr  = dn_dec[IDX_W-1:0];
          state_nxt = S_DN_CHK;
        end else begin
          b_nxt = el_rdata;
          if (up_r >= dn_r) begin
            state_nxt = S_FIN1;
          end else begin
            el_we     = 1'b1;
            el_waddr  = up_r[IDX_W-1:0];
            el_wdata  = el_rdata;
            state_nxt = S_SWAP2;
          end
        end
      end
      S_SWAP2: begin
        el_we     = 1'b1;
        el_waddr  = dn_r[IDX_W-1:0];
        el_wdata  = a_r;
        state_nxt = S_UP_STEP;
      end
      // place the pivot at its final index
      S_FIN1: begin
        el_we     = 1'b1;
        el_waddr  = lo_r;
        el_wdata  = b_r;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        el_we     = 1'b1;
        el_waddr  = dn_r[IDX_W-1:0];
        el_wdata  = pv_r;
        st_wdata  = '{lo: lo_r, hi: dn_dec[IDX_W-1:0]};
        state_nxt = S_PUSH_R;
        if (dn_r > lo_ext + cnt_t'(1) && sp_r < cnt_t'(DEPTH)) begin
          st_we  = 1'b1;
          sp_nxt = sp_r + cnt_t'(1);
        end
      end
      S_PUSH_R: begin
        st_wdata  = '{lo: dn_r[IDX_W-1:0] + idx_t'(1), hi: hi_r};
        state_nxt = S_POP;
        if (dn_r + cnt_t'(1) < hi_ext && sp_r < cnt_t'(DEPTH)) begin
          st_we  = 1'b1;
          sp_nxt = sp_r + cnt_t'(1);
        end
      end
      // ordered readout
      S_OUT_RD: begin
        el_raddr  = k_r[IDX_W-1:0];
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = el_rdata;
        out_fin_nxt   = (k_r + cnt_t'(1) == cnt_r);
        state_nxt     = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        el_raddr = k_r[IDX_W-1:0] + idx_t'(1);
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_fin_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + cnt_t'(1);
            state_nxt = S_OUT_WAIT;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      sp_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_fin_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sp_r        <= sp_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      out_fin_r   <= out_fin_nxt;
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    up_r      <= up_nxt;
    dn_r      <= dn_nxt;
    pv_r      <= pv_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    out_val_r <= out_val_nxt;
  end

endmodule

### test/tb_quicksort_engine_unit.sv
// self-checking testbench for the quicksort engine: loads sets, checks the sorted stream
`timescale 1ns / 1ps
module tb_quicksort_engine_unit
  import qse_pkg::*;
();

  localparam int    CLK_HALF    = 4;
  localparam int    RAND_ITEMS  = 94;
  localparam int    QUIET_START = 78;
  localparam int    HOLD_CYCLES = 500;
  localparam int    IDLE_LIMIT  = 20000;
  localparam int    DRAIN_WAIT  = 200;
  localparam data_t VAL_MAX     = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t VAL_MIN     = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // one expected transfer on the sorted output
  typedef struct {
    data_t value;
    logic  top_flag;
  } sorted_item_t;

  // collects the open set, predicts its sorted order, checks the output stream
  class sorted_set_tracker;
    data_t        open_set[$];
    sorted_item_t pending_sorted[$];
    int           errors;
    int           sets_closed;
    int           values_checked;

    function new();
      errors = 0;
      sets_closed = 0;
      values_checked = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function int pending_count();
      return pending_sorted.size();
    endfunction

    // note an accepted input transfer; a closing one yields the whole sorted set
    function void take_value(data_t v, logic l);
      data_t        vals[$];
      data_t        key;
      sorted_item_t item;
      int           j;
      open_set.push_back(v);
      if (!l && open_set.size() < DEPTH) return;
      vals = open_set;
      // insertion sort, signed ascending
      for (int i = 1; i < vals.size(); i++) begin
        key = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j+1] = vals[j];
          j--;
        end
        vals[j+1] = key;
      end
      foreach (vals[k]) begin
        item.value    = vals[k];
        item.top_flag = (k == vals.size() - 1);
        pending_sorted.push_back(item);
      end
      open_set.delete();
      sets_closed++;
    endfunction

    // compare one accepted output transfer with the oldest expectation
    task check_sorted(data_t v, logic f);
      sorted_item_t want;
      if (pending_sorted.size() == 0) begin
        report($sformatf("unexpected output value %0d final %0b", v, f));
        return;
      end
      want = pending_sorted.pop_front();
      values_checked++;
      if (v !== want.value)
        report($sformatf("sorted_value %0d, expected %0d", v, want.value));
      if (f !== want.top_flag)
        report($sformatf("final_res %0b, expected %0b (value %0d)", f, want.top_flag,
                         want.value));
    endtask
  endclass

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  data_t in_value;
  logic  in_last;
  logic  out_valid;
  logic  out_stall;
  data_t out_sorted_value;
  logic  out_final_res;

  sorted_set_tracker tracker;
  bit idle_on;
  bit stall_on;
  bit hold_req;
  int values_sent;
  int idle_cycles;

  quicksort_engine_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res)
  );

  // clock and reset
  initial begin
    clk   = 1'b0;
    rst_n = 1'b0;
    fork
      forever #CLK_HALF clk = ~clk;
      begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
      end
    join_none
  end

  // output back-pressure: random bursts, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.take_value(in_value, in_last);
      if (out_valid && !out_stall) tracker.check_sorted(out_sorted_value, out_final_res);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // offer one value, with an optional gap first, and wait for its transfer
  task automatic send_value(data_t v, logic l);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    values_sent++;
  endtask

  // mostly full-range values, some tight clusters for duplicates, some extremes
  function automatic data_t pick_value();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) return data_t'($urandom());
    if (mode < 8) return data_t'($urandom_range(0, 8) - 4);
    case ($urandom_range(0, 3))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  initial begin
    int    sent_rand;
    int    len;
    logic  l;
    tracker     = new();
    in_valid    = 1'b0;
    in_value    = '0;
    in_last     = 1'b0;
    idle_on     = 1'b1;
    stall_on    = 1'b1;
    hold_req    = 1'b0;
    values_sent = 0;
    idle_cycles = 0;
    sent_rand   = 0;
    wait (rst_n === 1'b1);

    // one-element sets at both extremes
    send_value(VAL_MAX, 1'b1);
    send_value(VAL_MIN, 1'b1);
    // extremes mixed in one set
    send_value('0, 1'b0);
    send_value('1, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(data_t'(1), 1'b1);
    // equal values stay grouped
    send_value(data_t'(7), 1'b0);
    send_value(data_t'(7), 1'b0);
    send_value(data_t'(-3), 1'b0);
    send_value(data_t'(7), 1'b0);
    send_value(data_t'(-3), 1'b1);
    // already ascending, then descending
    for (int i = -2; i <= 2; i++) send_value(data_t'(i), i == 2);
    for (int i = 3; i >= 1; i--) send_value(data_t'(i), i == 1);

    // random sets; the first fills the store and closes on count, with last set at random
    while (sent_rand < RAND_ITEMS) begin
      len = (sent_rand == 0) ? DEPTH : $urandom_range(1, 12);
      if (len > RAND_ITEMS - sent_rand) len = RAND_ITEMS - sent_rand;
      // long output hold while the next set is being offered
      if (sent_rand == DEPTH) hold_req = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (len == DEPTH)
          l = (k == len - 1) ? logic'($urandom_range(0, 1)) : 1'b0;
        else
          l = (k == len - 1);
        if (sent_rand >= QUIET_START) begin
          idle_on  = 1'b0;
          stall_on = 1'b0;
        end
        send_value(pick_value(), l);
        sent_rand++;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then keep watching for any stray transfer
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d sets from %0d input values, %0d sorted values checked",
             tracker.sets_closed, values_sent, tracker.values_checked);
    $display("sets ranged from single values to a full store, with extremes and repeats");
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
